// ===== hw/rtl/pao_pkg.sv =====
package pao_pkg;

    // Phase format: unsigned Q1.24, one full cycle is 2^24.
    localparam int PhaseW = 25;
    localparam int StepW = 24;
    localparam int TimeW = 64;
    localparam int SampleW = 20;
    localparam int WaveW = 16;
    localparam int GainW = 16;

    localparam logic [PhaseW-1:0] OneQ24 = PhaseW'(1) << 24;
    localparam logic [PhaseW-1:0] HalfQ24 = PhaseW'(1) << 23;
    localparam logic signed [WaveW-1:0] OneQ14 = WaveW'(16384);

    // Waveform select codes.
    localparam logic [1:0] ModeSaw = 2'd0;
    localparam logic [1:0] ModeSine = 2'd1;
    localparam logic [1:0] ModeSquare = 2'd2;

    // Register indexes and reset values.
    localparam int RegIdxW = 1;
    localparam logic [RegIdxW-1:0] RegWaveMode = 1'b0;
    localparam logic [RegIdxW-1:0] RegOutputGain = 1'b1;
    localparam logic [GainW-1:0] GainReset = 16'd4096;

    // Small word queues between and behind the two halves.
    localparam int QueuePtrW = 2;
    localparam int QueueDepth = 1 << QueuePtrW;
    localparam logic [QueuePtrW:0] QueueCntFull = (QueuePtrW + 1)'(QueueDepth);

    // Sine table: full depth is a power of two, only a quarter wave is stored.
    localparam int SineLog2 = 10;
    localparam int SineDepth = 1 << SineLog2;
    localparam int SineQuarter = SineDepth / 4;
    localparam int SineIdxW = SineLog2 - 1;
    localparam logic [SineIdxW-1:0] SineQuarterIdx = SineIdxW'(SineQuarter);

    localparam longint TaylorQ30 [5] = '{
        64'sd1686629713, -64'sd693598343, 64'sd85569304, -64'sd5026961, 64'sd172271
    };

    typedef logic [14:0] t_qtab [0:SineQuarter];

    // One word travelling from the front half to the back half.
    typedef struct packed {
        logic              recompute;
        logic [PhaseW-1:0] x;
    } t_work;

    // Live configuration seen by the back half.
    typedef struct packed {
        logic [1:0]       mode;
        logic [GainW-1:0] gain;
    } t_cfg;

    // Signed Q30 product, truncated toward zero.
    function automatic longint mul_q30(longint a, longint b);
        logic neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        m = (ma * mb) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Quarter-wave sine entry j, z = j / SineQuarter of a quarter cycle, result in Q14.
    function automatic logic [14:0] quarter_sine(int j);
        longint z;
        longint z2;
        longint acc;
        longint r;
        longint v;
        z = longint'(j) << (32 - SineLog2);
        z2 = mul_q30(z, z);
        acc = TaylorQ30[4];
        for (int k = 3; k >= 0; k--) begin
            acc = TaylorQ30[k] + mul_q30(acc, z2);
        end
        r = mul_q30(acc, z);
        if (r < 0) begin
            r = 0;
        end
        v = (r + (64'sd1 <<< 15)) >>> 16;
        if (v > 16384) begin
            v = 16384;
        end
        return v[14:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int j = 0; j <= SineQuarter; j++) begin
            tab[j] = quarter_sine(j);
        end
        return tab;
    endfunction

    localparam t_qtab SineQtab = build_qtab();

endpackage

// ===== hw/rtl/pao_front.sv =====
module pao_front import pao_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [TimeW-1:0] i_time_stamp,
    input  logic [StepW-1:0] i_phase_step,
    output t_work            o_work,
    output logic             o_work_vld,
    input  logic             i_work_pop
);

    logic [PhaseW-1:0] r_phase;
    logic [TimeW-1:0]  r_last_time;
    t_work             r_q [QueueDepth];
    logic [QueuePtrW-1:0] r_wr_ptr;
    logic [QueuePtrW-1:0] r_rd_ptr;
    logic [QueuePtrW:0]   r_cnt;

    logic              accept;
    logic              recompute;
    logic [PhaseW-1:0] sum;
    logic [PhaseW-1:0] n_x;
    logic [QueuePtrW:0] n_cnt;
    t_work             word;

    // Classify the word: only a strictly later time stamp advances the phase.
    assign accept = i_push && !o_full;
    assign recompute = i_time_stamp > r_last_time;
    assign sum = r_phase + PhaseW'(i_phase_step);
    assign n_x = (sum > OneQ24) ? '0 : sum;

    assign word.recompute = recompute;
    assign word.x = n_x;

    // Oscillator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_last_time <= '0;
        end else if (accept && recompute) begin
            r_phase <= n_x;
            r_last_time <= i_time_stamp;
        end
    end

    // Queue toward the back half.
    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = n_cnt + (QueuePtrW + 1)'(1);
        end
        if (i_work_pop) begin
            n_cnt = n_cnt - (QueuePtrW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QueuePtrW'(1);
            end
            if (i_work_pop) begin
                r_rd_ptr <= r_rd_ptr + QueuePtrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= word;
        end
    end

    assign o_full = (r_cnt == QueueCntFull);
    assign o_work_vld = (r_cnt != '0);
    assign o_work = r_q[r_rd_ptr];

`ifndef SYNTHESIS
    // The phase never rises above one full cycle.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= OneQ24)
        else $error("phase above 1.0");

    // A word that is not later leaves the oscillator state alone.
    a_hold_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !recompute) |=> ($stable(r_phase) && $stable(r_last_time)))
        else $error("state changed on a repeated time stamp");

    // The back half only pops words that are there.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_work_pop |-> o_work_vld)
        else $error("pop from empty work queue");
`endif

endmodule

// ===== hw/rtl/pao_back.sv =====
module pao_back import pao_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  t_work                     i_work,
    input  logic                      i_work_vld,
    output logic                      o_work_pop,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [SampleW-1:0] o_sample_out
);

    logic                      r_a_vld;
    logic                      r_a_rc;
    logic signed [WaveW-1:0]   r_a_wave;
    logic signed [SampleW-1:0] r_held;
    logic signed [SampleW-1:0] r_of [QueueDepth];
    logic [QueuePtrW-1:0]      r_of_wr;
    logic [QueuePtrW-1:0]      r_of_rd;
    logic [QueuePtrW:0]        r_of_cnt;

    logic [SineLog2-1:0]       sine_idx;
    logic [1:0]                quad;
    logic [SineIdxW-1:0]       low;
    logic [SineIdxW-1:0]       qidx;
    logic [WaveW-1:0]          mag;
    logic signed [WaveW-1:0]   sine_wave;
    logic signed [WaveW-1:0]   n_wave;
    logic signed [32:0]        prod;
    logic signed [SampleW-1:0] wdata;
    logic                      out_pop;
    logic [QueuePtrW:0]        n_of_cnt;

    // Take a word only when the result queue has room for it and the one in flight.
    assign o_work_pop = i_work_vld && ((r_of_cnt + (QueuePtrW + 1)'(r_a_vld)) < QueueCntFull);

    // Sine lookup: fold the index into the stored quarter wave, then restore the sign.
    assign sine_idx = i_work.x[23 -: SineLog2];
    assign quad = sine_idx[SineLog2-1 -: 2];
    assign low = {1'b0, sine_idx[SineLog2-3:0]};
    assign qidx = quad[0] ? (SineQuarterIdx - low) : low;
    assign mag = {1'b0, SineQtab[qidx]};
    assign sine_wave = quad[1] ? -$signed(mag) : $signed(mag);

    // Waveform select.
    always_comb begin
        unique case (i_cfg.mode)
            ModeSine:   n_wave = sine_wave;
            ModeSquare: n_wave = (i_work.x > HalfQ24) ? OneQ14 : '0;
            ModeSaw:    n_wave = $signed({1'b0, i_work.x[24:10]});
            default:    n_wave = $signed({1'b0, i_work.x[24:10]});
        endcase
    end

    // Waveform stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= o_work_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_pop) begin
            r_a_rc <= i_work.recompute;
            r_a_wave <= n_wave;
        end
    end

    // Gain stage: the arithmetic shift floors toward minus infinity.
    assign prod = r_a_wave * $signed({1'b0, i_cfg.gain});
    assign wdata = r_a_rc ? prod[31:12] : r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_a_vld && r_a_rc) begin
            r_held <= prod[31:12];
        end
    end

    // Result queue.
    assign out_pop = i_pop && !o_empty;

    always_comb begin
        n_of_cnt = r_of_cnt;
        if (r_a_vld) begin
            n_of_cnt = n_of_cnt + (QueuePtrW + 1)'(1);
        end
        if (out_pop) begin
            n_of_cnt = n_of_cnt - (QueuePtrW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wr <= '0;
            r_of_rd <= '0;
            r_of_cnt <= '0;
        end else begin
            r_of_cnt <= n_of_cnt;
            if (r_a_vld) begin
                r_of_wr <= r_of_wr + QueuePtrW'(1);
            end
            if (out_pop) begin
                r_of_rd <= r_of_rd + QueuePtrW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_of[r_of_wr] <= wdata;
        end
    end

    assign o_empty = (r_of_cnt == '0);
    assign o_sample_out = r_of[r_of_rd];

`ifndef SYNTHESIS
    // A word in the gain stage always finds a free result slot.
    a_room_for_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> (r_of_cnt < QueueCntFull))
        else $error("result queue overflow");

    // The waveform stays within plus or minus one in Q14.
    a_wave_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld |-> ((r_a_wave <= OneQ14) && (r_a_wave >= -OneQ14)))
        else $error("waveform out of range");

    // The held sample only moves when a recomputed word finishes.
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_a_vld && r_a_rc) |=> $stable(r_held))
        else $error("held sample changed without a recompute");
`endif

endmodule

// ===== hw/rtl/phase_accumulator_oscillator.sv =====
// Phase-accumulator oscillator.
// Input channel: a word (time stamp, phase step) is taken at a rising edge with
// push high and full low. A time stamp later than the last one advances the phase
// by the step (a phase above 1.0 restarts at zero) and forms a new sample; any
// other time stamp repeats the last sample. Each word gives exactly one result.
// Result channel: the oldest result is on o_sample_out while empty is low and is
// taken at an edge with pop high. Each result passes through the middle queue, the
// waveform register and the output queue. Throughput is one word per cycle while the
// receiver keeps up; the phase update is a single add and compare per cycle, and the
// back half runs a table lookup stage and a multiply stage. A four-word queue sits
// between the halves and another at the output, so a stalled receiver first fills
// the output queue, then the middle one, and only then raises full.
// Configuration is an APB port: wave_mode at address 0 (saw, sine, square; the
// unused code is ignored) and output_gain at address 4 (Q4.12). Write only
// while the block is idle. pready is always high.
// Reset clears phase, last time stamp and held sample, empties both queues,
// and sets the mode to saw and the gain to 1.0.
module phase_accumulator_oscillator import pao_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [TimeW-1:0]          i_time_stamp,
    input  logic [StepW-1:0]          i_phase_step,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [SampleW-1:0] o_sample_out,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [1:0]       r_wave_mode;
    logic [GainW-1:0] r_output_gain;

    logic               cfg_wr;
    logic [RegIdxW-1:0] cfg_idx;
    t_cfg               cfg;
    t_work              work;
    logic               work_vld;
    logic               work_pop;

    // Register file.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_mode <= ModeSaw;
            r_output_gain <= GainReset;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                RegWaveMode: begin
                    if (pwdata[1:0] <= ModeSquare) begin
                        r_wave_mode <= pwdata[1:0];
                    end
                end
                RegOutputGain: r_output_gain <= pwdata[GainW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            RegWaveMode:   prdata = {30'b0, r_wave_mode};
            RegOutputGain: prdata = {16'b0, r_output_gain};
            default:       prdata = '0;
        endcase
    end

    assign cfg.mode = r_wave_mode;
    assign cfg.gain = r_output_gain;

    // Front half: accept, classify, advance the phase.
    pao_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_time_stamp (i_time_stamp),
        .i_phase_step (i_phase_step),
        .o_work       (work),
        .o_work_vld   (work_vld),
        .i_work_pop   (work_pop)
    );

    // Back half: waveform, gain and result queue.
    pao_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_work       (work),
        .i_work_vld   (work_vld),
        .o_work_pop   (work_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_sample_out (o_sample_out)
    );

endmodule

// ===== tb/pao_sample_checker.sv =====
`timescale 1ns / 100ps

// Watches the word and register channels of the oscillator, predicts every
// sample and compares each popped word with the oldest prediction.
module pao_sample_checker import pao_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic [TimeW-1:0]          i_time_stamp,
    input  logic [StepW-1:0]          i_phase_step,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  logic signed [SampleW-1:0] i_sample_out,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [2:0]                i_paddr,
    input  logic [31:0]               i_pwdata,
    input  logic                      i_pready,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam logic [25:0] PhaseOne = 26'h100_0000;
    localparam logic [25:0] PhaseHalf = 26'h080_0000;
    localparam longint FullScale = 16384;
    localparam longint unsigned TableDepth = 1024;

    // Odd Taylor series of sin(pi/2 * z) in Q30, lowest power first.
    localparam longint SinCoef [5] = '{
        64'sd1686629713, -64'sd693598343, 64'sd85569304, -64'sd5026961, 64'sd172271
    };

    // Oscillator state and live register copies.
    logic [1:0]                cur_mode;
    logic [GainW-1:0]          cur_gain;
    logic [PhaseW-1:0]         osc_phase;
    logic [TimeW-1:0]          last_stamp;
    logic signed [SampleW-1:0] held_sample;

    logic signed [SampleW-1:0] samples_due [$];
    int                        fail_count = 0;

    assign o_fail_count = fail_count;

    // Q30 product with the magnitude truncated toward zero.
    function automatic longint q30_mul(longint a, longint b);
        logic neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Table entry idx of a full sine cycle, in Q2.14.
    function automatic longint sine_q14(int unsigned idx);
        longint unsigned ang;
        logic [1:0] quad;
        longint z;
        longint z2;
        longint acc;
        longint r;
        longint v;
        ang = (longint'(idx) << 32) / TableDepth;
        quad = ang[31:30];
        z = longint'(ang[29:0]);
        if (quad[0]) begin
            z = (64'sd1 <<< 30) - z;
        end
        z2 = q30_mul(z, z);
        acc = SinCoef[4];
        for (int k = 3; k >= 0; k--) begin
            acc = SinCoef[k] + q30_mul(acc, z2);
        end
        r = q30_mul(acc, z);
        if (r < 0) begin
            r = 0;
        end
        v = (r + 64'sd32768) >>> 16;
        if (v > FullScale) begin
            v = FullScale;
        end
        return quad[1] ? -v : v;
    endfunction

    // One oscillator step: recompute only for a strictly later time stamp.
    task automatic advance_oscillator(input logic [TimeW-1:0] ts, input logic [StepW-1:0] step,
                                      output logic signed [SampleW-1:0] smp);
        logic [25:0] x;
        longint wave;
        longint prod;
        if (ts > last_stamp) begin
            last_stamp = ts;
            x = osc_phase + step;
            // Above 1.0 the phase restarts at zero; exactly 1.0 is kept.
            if (x > PhaseOne) begin
                x = '0;
            end
            case (cur_mode)
                ModeSine: begin
                    wave = sine_q14(int'(x[23:14]));
                end
                ModeSquare: begin
                    wave = (x > PhaseHalf) ? FullScale : 0;
                end
                default: begin
                    wave = longint'(x >> 10);
                end
            endcase
            prod = (wave * longint'(cur_gain)) >>> 12;
            osc_phase = x[PhaseW-1:0];
            held_sample = prod[SampleW-1:0];
        end
        smp = held_sample;
    endtask

    always @(posedge i_clk) begin
        logic signed [SampleW-1:0] want;
        logic [1:0] new_mode;
        if (!i_rst_n) begin
            cur_mode = ModeSaw;
            cur_gain = GainReset;
            osc_phase = '0;
            last_stamp = '0;
            held_sample = '0;
            samples_due.delete();
        end else begin
            // Register writes; the unused mode code leaves the mode alone.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == RegWaveMode) begin
                    new_mode = i_pwdata[1:0];
                    if (new_mode == ModeSaw || new_mode == ModeSine ||
                        new_mode == ModeSquare) begin
                        cur_mode = new_mode;
                    end
                end else begin
                    cur_gain = i_pwdata[GainW-1:0];
                end
            end

            // Accepted input word.
            if (i_push && !i_full) begin
                advance_oscillator(i_time_stamp, i_phase_step, want);
                samples_due.push_back(want);
            end

            // Accepted result word.
            if (i_pop && !i_empty) begin
                if (samples_due.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: sample %0d popped with nothing expected",
                                 $realtime, i_sample_out);
                    end
                    fail_count++;
                end else begin
                    want = samples_due.pop_front();
                    if (i_sample_out !== want) begin
                        if (fail_count < 10) begin
                            $display("%0t: sample_out expected %0d, got %0d",
                                     $realtime, want, i_sample_out);
                        end
                        fail_count++;
                    end
                end
            end
        end
        o_pending <= samples_due.size();
    end

endmodule

// ===== tb/tb_phase_accumulator_oscillator.sv =====
`timescale 1ns / 100ps

module tb_phase_accumulator_oscillator;
    import pao_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int WordsPerPhase = 105;
    localparam logic [1:0] ModeUnused = 2'd3;
    localparam logic [2:0] AddrWaveMode = {RegWaveMode, 2'b00};
    localparam logic [2:0] AddrOutputGain = {RegOutputGain, 2'b00};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      push;
    logic                      full;
    logic [TimeW-1:0]          i_time_stamp;
    logic [StepW-1:0]          i_phase_step;
    logic                      empty;
    logic                      pop;
    logic signed [SampleW-1:0] o_sample_out;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    int                        fail_count;
    int                        pending;
    int unsigned               send_idle_pct = 0;
    int unsigned               pop_stall_pct = 0;
    int                        cycle_count = 0;
    int                        words_sent = 0;
    logic [TimeW-1:0]          stamp_now;

    phase_accumulator_oscillator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_time_stamp (i_time_stamp),
        .i_phase_step (i_phase_step),
        .empty        (empty),
        .pop          (pop),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    pao_sample_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_time_stamp (i_time_stamp),
        .i_phase_step (i_phase_step),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_sample_out (o_sample_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver side: pop is redrawn every falling edge.
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles with %0d samples outstanding",
                     cycle_count, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one word, with random idle cycles ahead of it. Starts and ends at a
    // falling edge; push stays high so that back-to-back words need no gap.
    task automatic send_word(input logic [TimeW-1:0] ts, input logic [StepW-1:0] step);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            i_time_stamp <= {$urandom, $urandom};
            i_phase_step <= StepW'($urandom);
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_time_stamp <= ts;
        i_phase_step <= step;
        do begin
            @(posedge i_clk);
        end while (full);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Lower push and wait until every sample has been popped.
    task automatic drain_samples();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random step: mostly uniform, with zero, full scale and small steps mixed in.
    function automatic logic [StepW-1:0] pick_step();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return StepW'($urandom_range(1, 4095));
            default: return StepW'($urandom);
        endcase
    endfunction

    // Random word: mostly later time stamps, the rest equal or earlier.
    task automatic send_random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            stamp_now = stamp_now + {22'd0, 10'($urandom), $urandom};
            send_word(stamp_now, pick_step());
        end else if (pick < 80) begin
            stamp_now = stamp_now + 64'($urandom_range(1, 200));
            send_word(stamp_now, pick_step());
        end else if (pick < 87) begin
            send_word(stamp_now, pick_step());
        end else begin
            send_word({$urandom, $urandom} % (stamp_now + 64'd1), pick_step());
        end
    endtask

    initial begin
        logic [15:0] gains [8];
        gains = '{16'hFFFF, 16'h0000, 16'h0001, 16'($urandom), GainReset, 16'h8000,
                  16'($urandom), 16'hFFFF};

        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_time_stamp = '0;
        i_phase_step = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Saw at unit gain from reset. A stamp equal to the reset value is stale.
        send_word(64'd0, 24'd123);
        send_word(64'd1, 24'd0);
        send_word(64'd2, 24'hFF_FFFF);
        // Phase lands exactly on 1.0 and is kept.
        send_word(64'd3, 24'd1);
        // Equal and earlier stamps repeat the held sample.
        send_word(64'd3, 24'd55);
        send_word(64'd2, 24'hFF_FFFF);
        // Just above 1.0 the phase restarts at zero.
        send_word(64'd4, 24'd1);
        send_word(64'd5, 24'h55_5555);
        send_word(64'd6, 24'hAA_AAAA);
        send_word(64'd7, 24'hFF_FFFF);
        drain_samples();

        // Sine at full gain, quarter steps through one cycle to 1.0, then a small step past it to zero.
        write_reg(AddrWaveMode, {30'd0, ModeSine});
        write_reg(AddrOutputGain, 32'h0000_FFFF);
        send_word(64'd8, 24'h40_0000);
        send_word(64'd9, 24'h40_0000);
        send_word(64'd10, 24'h40_0000);
        send_word(64'd11, 24'h40_0000);
        send_word(64'd12, 24'h00_0100);
        drain_samples();

        // Square at the smallest nonzero gain: exactly one half is still low.
        write_reg(AddrWaveMode, {30'd0, ModeSquare});
        write_reg(AddrOutputGain, 32'd1);
        send_word(64'd13, 24'h80_0000);
        send_word(64'd14, 24'd1);
        drain_samples();

        // The unused mode code must leave square selected.
        write_reg(AddrWaveMode, {30'd0, ModeUnused});
        write_reg(AddrOutputGain, {16'd0, GainReset});
        send_word(64'd15, 24'd1);
        drain_samples();

        // Random phases over all modes, a spread of gains and idle patterns.
        stamp_now = 64'd15;
        for (int p = 0; p < 8; p++) begin
            write_reg(AddrWaveMode, {30'd0, 2'(p % 3)});
            write_reg(AddrOutputGain, {16'd0, gains[p]});
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 86;
                    pop_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    pop_stall_pct = 86;
                end
                default: begin
                    send_idle_pct = 12;
                    pop_stall_pct = 12;
                end
            endcase
            for (int n = 0; n < WordsPerPhase; n++) begin
                send_random_word();
            end
            drain_samples();
        end

        // Largest time stamp last: after it every stamp is stale.
        send_idle_pct = 0;
        pop_stall_pct = 0;
        send_word('1, pick_step());
        send_word({$urandom, $urandom}, pick_step());
        drain_samples();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d words: stale and later stamps, phase at and past 1.0,",
                 words_sent);
        $display("saw, sine and square at gains 0 to 65535, idle and stall on both sides.");
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures, %0d samples outstanding", fail_count, pending);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
